@@ sv/vn_pkg.sv @@
`timescale 1ns / 1ps
package vn_pkg;
	localparam int ELEM_W = 31;
	localparam int OUT_W  = 18;
	localparam int SUM_W  = 64;
	localparam int ROOT_W = 32;

	// handoff from front to back: one closed vector and the RAM bank holding it
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             ovf;
		logic             bank;
	} vn_job_t;
endpackage

@@ sv/vn_front.sv @@
`timescale 1ns / 1ps
module vn_front #(
	parameter int MAX_LEN = 4,
	parameter int CW = 3,
	parameter int AW = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [vn_pkg::ELEM_W-1:0]  element,
	input  logic                              is_final,
	output logic                              job_valid,
	input  logic                              job_ready,
	output vn_pkg::vn_job_t                   job,
	output logic [CW-1:0]                     job_count,
	output logic                              wr_en,
	output logic [AW:0]                       wr_addr,
	output logic [vn_pkg::ELEM_W-1:0]         wr_data
);
	logic [CW-1:0]              count_q;
	logic [vn_pkg::SUM_W-1:0]   sum_q;
	logic                       ovf_q;
	logic                       bank_q;
	logic                       job_valid_q;
	vn_pkg::vn_job_t            job_q;
	logic [CW-1:0]              job_count_q;
	logic [vn_pkg::ELEM_W-1:0]  mag;
	logic [vn_pkg::SUM_W-1:0]   sq;
	logic [vn_pkg::SUM_W:0]     sum_add;
	logic                       take, room;
	logic [vn_pkg::SUM_W-1:0]   nsum;
	logic                       novf;

	function automatic logic [vn_pkg::ELEM_W-1:0] ELEM_W_NEG(
		input logic [vn_pkg::ELEM_W-1:0] v);
		ELEM_W_NEG = ~v + 1'b1;
	endfunction

	// stall while a closed vector waits for the back end
	assign in_ready  = !job_valid_q;
	assign take      = in_valid && in_ready;
	assign room      = count_q < CW'(MAX_LEN);
	assign mag       = element[vn_pkg::ELEM_W-1] ? ELEM_W_NEG(element) : element;
	assign sq        = {33'd0, mag} * {33'd0, mag};
	assign sum_add   = {1'b0, sum_q} + {1'b0, sq};
	assign wr_en     = take && room;
	// fill one bank while the back end reads the other
	assign wr_addr   = {bank_q, count_q[AW-1:0]};
	assign wr_data   = element;
	assign job_valid = job_valid_q;
	assign job       = job_q;
	assign job_count = job_count_q;

	always_comb begin
		nsum = sum_q;
		novf = ovf_q;
		if (room) begin
			if (sum_add[vn_pkg::SUM_W]) begin
				nsum = '1;
				novf = 1'b1;
			end else begin
				nsum = sum_add[vn_pkg::SUM_W-1:0];
			end
		end else begin
			novf = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			bank_q      <= 1'b0;
			job_valid_q <= 1'b0;
		end else begin
			if (job_valid_q && job_ready) job_valid_q <= 1'b0;
			if (take) begin
				if (is_final) begin
					job_valid_q <= 1'b1;
					count_q     <= '0;
					sum_q       <= '0;
					ovf_q       <= 1'b0;
					bank_q      <= ~bank_q;
				end else begin
					if (room) count_q <= count_q + 1'b1;
					sum_q <= nsum;
					ovf_q <= novf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_final) begin
			job_q.sum   <= nsum;
			job_q.ovf   <= novf;
			job_q.bank  <= bank_q;
			job_count_q <= room ? count_q + 1'b1 : count_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_LEN))
		else $error("count past capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		take && is_final |=> job_valid_q && count_q == '0)
		else $error("vector not closed");
	assert property (@(posedge clk) disable iff (!arst_n) job_valid_q |-> !in_ready)
		else $error("accepted while job pending");
endmodule

@@ sv/vn_ram.sv @@
`timescale 1ns / 1ps
module vn_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 4,
	parameter int AW = 2
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end
endmodule

@@ sv/vn_back.sv @@
`timescale 1ns / 1ps
module vn_back #(
	parameter int MAX_LEN = 4,
	parameter int CW = 3,
	parameter int AW = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              job_valid,
	output logic                              job_ready,
	input  vn_pkg::vn_job_t                   job,
	input  logic [CW-1:0]                     job_count,
	output logic [AW:0]                       rd_addr,
	input  logic [vn_pkg::ELEM_W-1:0]         rd_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [vn_pkg::OUT_W-1:0]   unit_component,
	output logic                              end_of_vector,
	output logic                              zero_length,
	output logic                              overflowed
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROOT = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam int QW = 48; // |c|<<16 fits in 47 bits

	logic [2:0]               state_q;
	logic [vn_pkg::SUM_W-1:0] rem_q;
	logic [vn_pkg::ROOT_W-1:0] root_q;
	logic [5:0]               step_q;
	logic [CW-1:0]            n_q, idx_q;
	logic                     ovf_q;
	logic                     bank_q;
	logic [QW-1:0]            dvd_q;
	logic [vn_pkg::ROOT_W:0]  drem_q;
	logic                     neg_q;
	logic                     out_valid_q;
	logic signed [vn_pkg::OUT_W-1:0] res_q;
	logic                     eov_q, zero_q, oflag_q;
	logic [vn_pkg::ROOT_W+1:0] trial;
	logic [vn_pkg::ROOT_W+1:0] dtry;
	logic [vn_pkg::ROOT_W:0]   dshift;
	logic [vn_pkg::ELEM_W-1:0] cmag;
	logic [16:0]               qclamp;
	logic [vn_pkg::ROOT_W+1:0] rtop_q;
	logic [vn_pkg::ROOT_W+2:0] rdiff;

	assign job_ready      = state_q == ST_IDLE;
	assign rd_addr        = {bank_q, idx_q[AW-1:0]};
	assign out_valid      = out_valid_q;
	assign unit_component = res_q;
	assign end_of_vector  = eov_q;
	assign zero_length    = zero_q;
	assign overflowed     = oflag_q;

	// restoring root: two radicand bits a cycle
	assign trial = {root_q, 2'b01};
	assign rdiff = {rtop_q[vn_pkg::ROOT_W:0], rem_q[vn_pkg::SUM_W-1 -: 2]} - {1'b0, trial};
	assign dshift = {drem_q[vn_pkg::ROOT_W-1:0], dvd_q[QW-1]};
	assign dtry  = {1'b0, dshift} - {2'b00, root_q};
	assign cmag  = rd_data[vn_pkg::ELEM_W-1] ? ~rd_data + 1'b1 : rd_data;
	assign qclamp = (dvd_q > 48'd65536) ? 17'd65536 : dvd_q[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (job_valid) begin
					rem_q   <= job.sum;
					rtop_q  <= '0;
					root_q  <= '0;
					ovf_q   <= job.ovf;
					bank_q  <= job.bank;
					n_q     <= job_count;
					idx_q   <= '0;
					step_q  <= '0;
					state_q <= job_count == '0 ? ST_IDLE : ST_ROOT;
				end
				ST_ROOT: begin
					rem_q <= {rem_q[vn_pkg::SUM_W-3:0], 2'b00};
					if (!rdiff[vn_pkg::ROOT_W+2]) begin
						rtop_q <= rdiff[vn_pkg::ROOT_W+1:0];
						root_q <= {root_q[vn_pkg::ROOT_W-2:0], 1'b1};
					end else begin
						rtop_q <= {rtop_q[vn_pkg::ROOT_W-1:0], rem_q[vn_pkg::SUM_W-1 -: 2]};
						root_q <= {root_q[vn_pkg::ROOT_W-2:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == 6'd31) state_q <= ST_READ;
				end
				ST_READ: begin
					// RAM read data is registered; wait for it, then load dividend
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0) begin
						dvd_q  <= {1'b0, cmag, 16'd0};
						drem_q <= '0;
						neg_q  <= rd_data[vn_pkg::ELEM_W-1];
						step_q <= 6'd1;
					end else begin
						if (!dtry[vn_pkg::ROOT_W+1]) begin
							drem_q <= dtry[vn_pkg::ROOT_W:0];
							dvd_q  <= {dvd_q[QW-2:0], 1'b1};
						end else begin
							drem_q <= dshift;
							dvd_q  <= {dvd_q[QW-2:0], 1'b0};
						end
						step_q <= step_q + 1'b1;
						if (step_q == 6'(QW)) state_q <= ST_OUT;
					end
				end
				ST_OUT: if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
					res_q   <= root_q == '0 ? '0 :
						(neg_q ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp}));
					eov_q   <= idx_q + 1'b1 == n_q;
					zero_q  <= root_q == '0;
					oflag_q <= ovf_q;
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_q + 1'b1 == n_q) ? ST_IDLE : ST_READ;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_valid_q && out_ready && !(state_q == ST_OUT)) out_valid_q <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid_q && zero_q |-> res_q == '0)
		else $error("zero-length beat carries a value");
	assert property (@(posedge clk) disable iff (!arst_n) state_q == ST_OUT |-> idx_q < n_q)
		else $error("index past vector");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> n_q <= CW'(MAX_LEN))
		else $error("job longer than capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("result dropped");
endmodule

@@ sv/vector_normalize_core.sv @@
`timescale 1ns / 1ps
// vector_normalize_core: Euclidean normalization of a vector; unit components in signed Q2.16.
// Input channel in_valid/in_ready carries one component a beat with
// is_final closing the vector. Output channel out_valid/out_ready carries
// one unit component a beat; end_of_vector marks the last one, zero_length
// and overflowed repeat on every beat of a vector.
// The front end takes components at one a cycle, stores up to MAX_LEN in one
// bank of a two-bank RAM and keeps a saturating 64-bit sum of squares.
// Components past MAX_LEN are dropped and flag overflow. Closing a vector
// hands one job to the back end through a one-entry queue and flips the
// bank; the front stalls only while that slot is full.
// The back end takes the job, runs a restoring square root (two radicand
// bits a cycle), then per component does a RAM read, a dividend load, a
// restoring division and an output step. It accepts the next job only
// once the last beat of the current vector has gone into the output register.
// A stalled receiver holds the output register and stops the back end at its output step;
// the front keeps collecting the next vector into the other bank. Reset
// clears all control state; the RAM holds no reset value and is read only
// after writing.
module vector_normalize_core #(
	parameter int MAX_LEN = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [vn_pkg::ELEM_W-1:0]  element,
	input  logic                              is_final,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [vn_pkg::OUT_W-1:0]   unit_component,
	output logic                              end_of_vector,
	output logic                              zero_length,
	output logic                              overflowed
);
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	logic                      job_valid, job_ready;
	vn_pkg::vn_job_t           job;
	logic [CW-1:0]             job_count;
	logic                      wr_en;
	logic [AW:0]               wr_addr, rd_addr;
	logic [vn_pkg::ELEM_W-1:0] wr_data, rd_data;

	vn_front #(.MAX_LEN(MAX_LEN), .CW(CW), .AW(AW)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .element, .is_final,
		.job_valid, .job_ready, .job, .job_count, .wr_en, .wr_addr, .wr_data
	);

	// two banks: bank bit on top of the component index
	vn_ram #(.WIDTH(vn_pkg::ELEM_W), .DEPTH(2 ** (AW + 1)), .AW(AW + 1)) u_ram (
		.clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
	);

	vn_back #(.MAX_LEN(MAX_LEN), .CW(CW), .AW(AW)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job, .job_count, .rd_addr, .rd_data,
		.out_valid, .out_ready, .unit_component, .end_of_vector, .zero_length,
		.overflowed
	);
endmodule

@@ verif/vector_normalize_core_test.sv @@
`timescale 1ns / 1ps
module vector_normalize_core_test;
	localparam int ELEM_W      = vn_pkg::ELEM_W;
	localparam int OUT_W       = vn_pkg::OUT_W;
	localparam int SUM_W       = vn_pkg::SUM_W;
	localparam int MAX_LEN     = 4;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 600;
	localparam int TAIL_CYCLES = 200;

	// one normalized beat as the receiver should see it
	typedef struct {
		logic signed [OUT_W-1:0] unit_component;
		logic                    end_of_vector;
		logic                    zero_length;
		logic                    overflowed;
	} unit_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [ELEM_W-1:0] element = '0;
	logic is_final = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] unit_component;
	logic end_of_vector;
	logic zero_length;
	logic overflowed;

	// predictor copy of the block's vector state
	logic signed [ELEM_W-1:0] held_components[MAX_LEN];
	int unsigned              held_count = 0;
	logic [SUM_W-1:0]         squares_total = '0;
	logic                     dropped_or_sat = 1'b0;

	unit_beat_t pending_units[$];
	int  mismatch_count = 0;
	int  idle_cycles = 0;
	bit  dense_mode = 1'b0;
	bit  hold_receiver = 1'b0;

	vector_normalize_core #(.MAX_LEN(MAX_LEN)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.element(element), .is_final(is_final),
		.out_valid(out_valid), .out_ready(out_ready),
		.unit_component(unit_component), .end_of_vector(end_of_vector),
		.zero_length(zero_length), .overflowed(overflowed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// floor square root, two radicand bits per pass
	function automatic logic [SUM_W-1:0] floor_root(logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] root;
		logic [SUM_W-1:0] probe;
		root = '0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v = v - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// fold one accepted component into the vector; on the final one,
	// queue every unit component it produces and clear
	task automatic absorb_component(logic signed [ELEM_W-1:0] e, logic fin);
		longint signed    c;
		logic [SUM_W-1:0] mag;
		logic [SUM_W-1:0] sq;
		logic [SUM_W-1:0] len;
		logic [SUM_W-1:0] quo;
		unit_beat_t       b;
		if (held_count < MAX_LEN) begin
			c = e;
			mag = c < 0 ? -c : c;
			sq = mag * mag;
			held_components[held_count] = e;
			held_count++;
			if (squares_total > ~sq) begin
				squares_total = '1;
				dropped_or_sat = 1'b1;
			end else begin
				squares_total = squares_total + sq;
			end
		end else begin
			dropped_or_sat = 1'b1;
		end
		if (!fin)
			return;
		len = floor_root(squares_total);
		for (int i = 0; i < held_count; i++) begin
			c = held_components[i];
			b.unit_component = '0;
			if (len != 0) begin
				mag = c < 0 ? -c : c;
				quo = (mag << 16) / len;
				if (quo > 65536)
					quo = 65536;
				b.unit_component = c < 0 ? -quo[OUT_W-1:0] : quo[OUT_W-1:0];
			end
			b.end_of_vector = (i + 1 == held_count);
			b.zero_length = (len == 0);
			b.overflowed = dropped_or_sat;
			pending_units.push_back(b);
		end
		held_count = 0;
		squares_total = '0;
		dropped_or_sat = 1'b0;
	endtask

	// offer one component; hold it until the block takes the beat
	task automatic send_component(logic signed [ELEM_W-1:0] e, logic fin);
		int r;
		int gap;
		r = $urandom_range(0, 19);
		gap = dense_mode ? 0 : (r < 12 ? 0 : (r < 18 ? $urandom_range(1, 3)
			: $urandom_range(10, 40)));
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		element = e;
		is_final = fin;
		do @(posedge clk); while (!in_ready);
		absorb_component(e, fin);
		@(negedge clk);
	endtask

	function automatic logic signed [ELEM_W-1:0] pick_element();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return ELEM_W'($urandom_range(0, 200) - 100);
			2: return $urandom_range(0, 1) ? 31'sh3FFFFFFF : 31'sh40000000;
			3: return ELEM_W'($urandom_range(0, 1 << 20) - (1 << 19));
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	task automatic send_vector(int n);
		for (int i = 0; i < n; i++)
			send_component(pick_element(), i == n - 1);
	endtask

	// extremes, zero vector, single component, overflow and a dropped final
	task automatic test_directed();
		send_component(31'sh3FFFFFFF, 1'b0);
		send_component(31'sh40000000, 1'b1);
		send_component(31'sh0, 1'b0);
		send_component(31'sh0, 1'b0);
		send_component(31'sh0, 1'b1);
		send_component(31'sh1, 1'b1);
		send_component(-31'sh1, 1'b1);
		send_component(31'sh3, 1'b0);
		send_component(-31'sh4, 1'b1);
		for (int i = 0; i < 6; i++)
			send_component(ELEM_W'(31'sh10000 * (i + 1)), i == 5);
		for (int i = 0; i < 4; i++)
			send_component(-31'sh20000, 1'b0);
		send_component(31'sh7FFF, 1'b1);
		send_component(31'sh0, 1'b0);
		send_component(31'sh5, 1'b1);
	endtask

	task automatic test_random_vectors();
		int sent;
		int n;
		sent = 0;
		while (sent < 220) begin
			if ($urandom_range(0, 15) == 0)
				dense_mode = ~dense_mode;
			n = $urandom_range(0, 9) < 8 ? $urandom_range(1, MAX_LEN)
				: $urandom_range(MAX_LEN + 1, MAX_LEN + 3);
			send_vector(n);
			sent += n;
		end
		dense_mode = 1'b0;
	endtask

	// stall the receiver long enough that the block backs up its input
	task automatic test_output_hold();
		hold_receiver = 1'b1;
		dense_mode = 1'b1;
		repeat (4) send_vector(MAX_LEN);
		dense_mode = 1'b0;
	endtask

	// pause the sender until every expected beat has drained
	task automatic test_drain_pause();
		in_valid = 1'b0;
		wait (pending_units.size() == 0);
		@(negedge clk);
		send_vector(3);
	endtask

	// receiver readiness: random gaps, with one long hold on request
	initial begin
		int r;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_receiver) begin
				hold_receiver = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			r = $urandom_range(0, 19);
			if (r < 13) begin
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b0;
				repeat (r < 19 ? $urandom_range(1, 3) : $urandom_range(10, 40))
					@(negedge clk);
				out_ready = 1'b1;
			end
		end
	end

	// compare each taken beat against the oldest expectation
	always @(posedge clk) begin
		unit_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_units.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected beat: unit %0d eov %b zero %b ovf %b",
						unit_component, end_of_vector, zero_length, overflowed);
			end else begin
				want = pending_units.pop_front();
				if (unit_component !== want.unit_component
					|| end_of_vector !== want.end_of_vector
					|| zero_length !== want.zero_length
					|| overflowed !== want.overflowed) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("beat mismatch: want %0d/%b/%b/%b got %0d/%b/%b/%b",
							want.unit_component, want.end_of_vector,
							want.zero_length, want.overflowed, unit_component,
							end_of_vector, zero_length, overflowed);
				end
			end
		end
	end

	// watchdog: count cycles with no beat moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("vector_normalize_core_test: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_output_hold();
		test_drain_pause();
		test_random_vectors();
		in_valid = 1'b0;
		wait (pending_units.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_units.size() == 0)
			$display("vector_normalize_core_test: done, clean");
		else
			$display("vector_normalize_core_test: done, errors");
		$finish;
	end
endmodule

@@ filelist.f @@
sv/vn_pkg.sv
sv/vn_front.sv
sv/vn_ram.sv
sv/vn_back.sv
sv/vector_normalize_core.sv
verif/vector_normalize_core_test.sv
